FILE: rtl/core/thdr_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, reset values and types of the touch debounce block.
package thdr_pkg;

   localparam int MAX_POINTS_DEF = 5;
   localparam int COORD_BITS     = 12;

   localparam int KIND_W    = 2;
   localparam int RAW_W     = 12;
   localparam int AREA_W    = 16;
   localparam int FCOUNT_W  = 8;
   localparam int ID_W      = 3;
   localparam int RCOUNT_W  = 3;
   localparam int ROT_W     = 2;
   localparam int DIM_W     = 13;
   localparam int MS_W      = 16;
   localparam int LIMIT_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int ENTRY_W   = 2 * COORD_BITS + AREA_W;

   localparam int DIM_TOP = 1 << COORD_BITS;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POINT = 2'd2;

   localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_LIMIT = 3'd4;

   localparam logic [ROT_W-1:0]   ROTATION_RST = ROT_0;
   localparam logic [DIM_W-1:0]   WIDTH_RST    = 13'd320;
   localparam logic [DIM_W-1:0]   HEIGHT_RST   = 13'd480;
   localparam logic [MS_W-1:0]    DEBOUNCE_RST = 16'd50;
   localparam int                 LIMIT_RST    = 5;

   typedef struct packed {
      logic [ROT_W-1:0] rotation;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } geom_type;

   // A panel dimension of zero acts as one, and one above the coordinate range is capped.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (32'(d) > DIM_TOP) begin
         r = DIM_W'(DIM_TOP);
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/thdr_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the touch debounce block: request, response and register write.
interface thdr_req_if;
   import thdr_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [RAW_W-1:0]    raw_x;
   logic [RAW_W-1:0]    raw_y;
   logic [AREA_W-1:0]   raw_area;
   logic [FCOUNT_W-1:0] frame_count;
   logic                frame_end;
   modport source (output valid, kind, raw_x, raw_y, raw_area, frame_count, frame_end,
                   input ready);
   modport sink   (input valid, kind, raw_x, raw_y, raw_area, frame_count, frame_end,
                   output ready);
endinterface

interface thdr_rsp_if;
   import thdr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;
   logic [AREA_W-1:0]     out_strength;
   logic [ID_W-1:0]       out_id;
   logic [RCOUNT_W-1:0]   reported_count;
   logic                  last;
   modport source (output valid, out_x, out_y, out_strength, out_id, reported_count, last,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_strength, out_id, reported_count, last,
                   output ready);
endinterface

interface thdr_csr_if;
   import thdr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, reg_index, data, input ready);
   modport sink   (input valid, reg_index, data, output ready);
endinterface

FILE: rtl/core/thdr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module thdr_ram #(
   parameter int WIDTH = thdr_pkg::ENTRY_W,
   parameter int DEPTH = thdr_pkg::MAX_POINTS_DEF
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/thdr_map.sv
`timescale 1ns / 1ps
// Quarter-turn rotation of a raw touch point and clamping to the rotated screen bounds.
module thdr_map (
   input  thdr_pkg::geom_type                 geom,
   input  logic [thdr_pkg::RAW_W-1:0]         raw_x,
   input  logic [thdr_pkg::RAW_W-1:0]         raw_y,
   output logic [thdr_pkg::COORD_BITS-1:0]    map_x,
   output logic [thdr_pkg::COORD_BITS-1:0]    map_y
);
   import thdr_pkg::*;

   localparam int SW = DIM_W + 1;

   logic signed [SW-1:0] rx_s, ry_s, w_s, h_s, x_s, y_s, mx_s, my_s;

   function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                   input logic signed [SW-1:0] hi);
      logic [COORD_BITS-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > hi) begin
         r = hi[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   assign rx_s = $signed(SW'(raw_x));
   assign ry_s = $signed(SW'(raw_y));
   assign w_s  = $signed(SW'(geom.width));
   assign h_s  = $signed(SW'(geom.height));

   always_comb begin
      case (geom.rotation)
         ROT_90: begin
            x_s = ry_s;
            y_s = w_s - rx_s;
         end
         ROT_180: begin
            x_s = w_s - rx_s;
            y_s = h_s - ry_s;
         end
         ROT_270: begin
            x_s = h_s - ry_s;
            y_s = rx_s;
         end
         default: begin
            x_s = rx_s;
            y_s = ry_s;
         end
      endcase
      if (geom.rotation[0]) begin
         mx_s = h_s - SW'(1);
         my_s = w_s - SW'(1);
      end else begin
         mx_s = w_s - SW'(1);
         my_s = h_s - SW'(1);
      end
   end

   assign map_x = clamp(x_s, mx_s);
   assign map_y = clamp(y_s, my_s);

endmodule

FILE: rtl/core/touch_hold_debounce_rotate.sv
`timescale 1ns / 1ps
// Touch poll debouncer: caches rotated points in a RAM and reports or replays them per poll.
// Ticks, unused items and points that do not end a poll are accepted one per cycle while the
// block is idle. A poll's results pass through the state register, the registered cache read
// and the result register, then follow one per cycle while the receiver is ready; the next item
// is accepted once the last one is loaded, as it is after the single release result.
// Synchronous reset restores the register defaults and clears control state, not the cache.
module touch_hold_debounce_rotate #(
   parameter int MAX_POINTS = thdr_pkg::MAX_POINTS_DEF
) (
   input logic          clock,
   input logic          reset,
   thdr_req_if.sink     req_ch,
   thdr_rsp_if.source   rsp_ch,
   thdr_csr_if.sink     csr_ch
);
   import thdr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_POINTS);
   localparam logic [CNT_W-1:0] LIMIT_DEF =
      CNT_W'((LIMIT_RST > MAX_POINTS) ? MAX_POINTS : LIMIT_RST);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_REL  = 2'd3;

   geom_type          geom_ff;
   logic [MS_W-1:0]   debounce_ff;
   logic [CNT_W-1:0]  limit_ff;
   logic [LIMIT_W-1:0] limit_raw;

   logic [1:0]        state_ff, state_in;
   logic              active_ff, active_in;
   logic [CNT_W-1:0]  cached_ff, cached_in;
   logic [MS_W-1:0]   elapsed_ff, elapsed_in;
   logic [CNT_W-1:0]  wi_ff, wi_in;
   logic [CNT_W-1:0]  emit_n_ff, emit_n_in;
   logic [CNT_W-1:0]  emit_i_ff, emit_i_in;
   logic [CNT_W-1:0]  emit_rd_ff, emit_rd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   logic                  rsp_last_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [AREA_W-1:0]     rsp_str_ff, rsp_str_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [RCOUNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff;

   logic                  req_acc, fcount_nz, do_write, empty_poll, frame_done, bridge;
   logic                  out_free, last_now;
   logic [CNT_W-1:0]      wi_pt, fc_n, n_fr, n_rep;
   logic [COORD_BITS-1:0] map_x, map_y;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]    rd_data;

   // Register writes.
   assign csr_ch.ready = 1'b1;
   assign limit_raw    = csr_ch.data[LIMIT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.rotation <= ROTATION_RST;
         geom_ff.width    <= WIDTH_RST;
         geom_ff.height   <= HEIGHT_RST;
         debounce_ff      <= DEBOUNCE_RST;
         limit_ff         <= LIMIT_DEF;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            CSR_ROTATION:     geom_ff.rotation <= csr_ch.data[ROT_W-1:0];
            CSR_PANEL_WIDTH:  geom_ff.width    <= eff_dim(csr_ch.data[DIM_W-1:0]);
            CSR_PANEL_HEIGHT: geom_ff.height   <= eff_dim(csr_ch.data[DIM_W-1:0]);
            CSR_DEBOUNCE_MS:  debounce_ff      <= csr_ch.data[MS_W-1:0];
            CSR_REPORT_LIMIT: begin
               if (limit_raw == '0) begin
                  limit_ff <= CNT_W'(1);
               end else if (32'(limit_raw) > MAX_POINTS) begin
                  limit_ff <= MAX_CNT;
               end else begin
                  limit_ff <= CNT_W'(limit_raw);
               end
            end
            default: ;
         endcase
      end
   end

   thdr_map u_map (
      .geom  (geom_ff),
      .raw_x (req_ch.raw_x),
      .raw_y (req_ch.raw_y),
      .map_x (map_x),
      .map_y (map_y)
   );

   thdr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_cache (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wi_ff[ADDR_W-1:0]),
      .wr_data ({map_x, map_y, req_ch.raw_area}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign fcount_nz    = (req_ch.frame_count != '0);
   assign do_write     = req_acc && (req_ch.kind == KIND_POINT) && fcount_nz &&
                         (wi_ff < MAX_CNT);
   assign wi_pt        = do_write ? wi_ff + CNT_W'(1) : wi_ff;
   assign fc_n         = (32'(req_ch.frame_count) > MAX_POINTS) ? MAX_CNT
                                                                : CNT_W'(req_ch.frame_count);
   assign n_fr         = (fc_n < wi_pt) ? fc_n : wi_pt;
   assign n_rep        = (cached_ff < limit_ff) ? cached_ff : limit_ff;
   assign bridge       = active_ff && (elapsed_ff < debounce_ff) && (cached_ff != '0);
   assign empty_poll   = req_acc && ((req_ch.kind == KIND_EMPTY) ||
                         ((req_ch.kind == KIND_POINT) && req_ch.frame_end && !fcount_nz));
   assign frame_done   = req_acc && (req_ch.kind == KIND_POINT) && req_ch.frame_end &&
                         fcount_nz;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign last_now     = (emit_i_ff + CNT_W'(1) == emit_n_ff);

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      cached_in   = cached_ff;
      elapsed_in  = elapsed_ff;
      wi_in       = wi_ff;
      emit_n_in   = emit_n_ff;
      emit_i_in   = emit_i_ff;
      emit_rd_in  = emit_rd_ff;
      rd_en       = 1'b0;
      rd_addr     = emit_rd_ff[ADDR_W-1:0];
      rsp_load    = 1'b0;
      rsp_x_in    = rd_data[ENTRY_W-1 -: COORD_BITS];
      rsp_y_in    = rd_data[AREA_W +: COORD_BITS];
      rsp_str_in  = rd_data[AREA_W-1:0];
      rsp_id_in   = ID_W'(emit_i_ff);
      rsp_cnt_in  = RCOUNT_W'(emit_n_ff);
      rsp_last_in = last_now;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_ch.kind == KIND_TICK) && (elapsed_ff != '1)) begin
               elapsed_in = elapsed_ff + MS_W'(1);
            end
            if (req_acc && (req_ch.kind == KIND_POINT)) begin
               wi_in = wi_pt;
            end
            if (empty_poll) begin
               wi_in = '0;
               if (bridge) begin
                  emit_n_in  = n_rep;
                  emit_i_in  = '0;
                  emit_rd_in = '0;
                  state_in   = S_READ;
               end else begin
                  active_in = 1'b0;
                  cached_in = '0;
                  state_in  = S_REL;
               end
            end
            if (frame_done) begin
               wi_in      = '0;
               active_in  = 1'b1;
               cached_in  = n_fr;
               elapsed_in = '0;
               emit_n_in  = (n_fr < limit_ff) ? n_fr : limit_ff;
               emit_i_in  = '0;
               emit_rd_in = '0;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            rd_en      = 1'b1;
            emit_rd_in = emit_rd_ff + CNT_W'(1);
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               emit_i_in = emit_i_ff + CNT_W'(1);
               if (last_now) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en      = 1'b1;
                  emit_rd_in = emit_rd_ff + CNT_W'(1);
               end
            end
         end
         S_REL: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_x_in    = '0;
               rsp_y_in    = '0;
               rsp_str_in  = '0;
               rsp_id_in   = '0;
               rsp_cnt_in  = '0;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         cached_ff    <= '0;
         elapsed_ff   <= '0;
         wi_ff        <= '0;
         emit_n_ff    <= '0;
         emit_i_ff    <= '0;
         emit_rd_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         cached_ff    <= cached_in;
         elapsed_ff   <= elapsed_in;
         wi_ff        <= wi_in;
         emit_n_ff    <= emit_n_in;
         emit_i_ff    <= emit_i_in;
         emit_rd_ff   <= emit_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_str_ff  <= rsp_str_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_x          = rsp_x_ff;
   assign rsp_ch.out_y          = rsp_y_ff;
   assign rsp_ch.out_strength   = rsp_str_ff;
   assign rsp_ch.out_id         = rsp_id_ff;
   assign rsp_ch.reported_count = rsp_cnt_ff;
   assign rsp_ch.last           = rsp_last_ff;

   a_count_matches_active: assert property (@(posedge clock) disable iff (reset)
      (cached_ff != '0) == active_ff)
      else $error("Cached point count disagrees with the touch state.");

   a_write_index_bound: assert property (@(posedge clock) disable iff (reset)
      wi_ff <= MAX_CNT)
      else $error("Cache write index beyond the cache depth.");

   a_emit_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_WAIT) |->
         (emit_i_ff < emit_n_ff) && (emit_rd_ff <= emit_n_ff) && (emit_n_ff <= limit_ff))
      else $error("Replay counters out of range.");

   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> active_ff && (elapsed_ff == '0) && (state_ff == S_READ))
      else $error("Completed poll did not start a report.");

   a_final_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && out_free && last_now) |=>
         (state_ff == S_IDLE) && rsp_ch.valid && rsp_ch.last)
      else $error("Final transaction of a poll not marked last.");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the touch debounce block with its own result predictor.
module testbench;
   import thdr_pkg::*;

   localparam int MAX_PTS = MAX_POINTS_DEF;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int ELAPSED_TOP = 65535;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [AREA_W-1:0]     strength;
      logic [ID_W-1:0]       id;
      logic [RCOUNT_W-1:0]   count;
      logic                  last;
   } touch_report_type;

   logic clock;
   logic reset;

   thdr_req_if req_if ();
   thdr_rsp_if rsp_if ();
   thdr_csr_if csr_if ();

   touch_hold_debounce_rotate dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Predicted register contents.
   logic [ROT_W-1:0]   cfg_rotation;
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;
   logic [MS_W-1:0]    cfg_debounce;
   logic [LIMIT_W-1:0] cfg_limit;

   // Predicted debounce state and point cache.
   logic                  touch_active;
   int                    cached_count;
   int                    elapsed;
   int                    write_idx;
   logic [COORD_BITS-1:0] cache_x [MAX_PTS];
   logic [COORD_BITS-1:0] cache_y [MAX_PTS];
   logic [AREA_W-1:0]     cache_strength [MAX_PTS];

   touch_report_type pending_reports [$];

   int req_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_req;
   int hold_left;
   int tick_span;
   int items_sent;
   int reports_checked;
   int mismatches;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results outstanding.",
                  pending_reports.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_req != 0) begin
         hold_left = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      touch_report_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected result transaction: out_x %0d out_y %0d last %0d",
                   rsp_if.out_x, rsp_if.out_y, rsp_if.last);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("out_x", 32'(want.x), 32'(rsp_if.out_x));
            check_field("out_y", 32'(want.y), 32'(rsp_if.out_y));
            check_field("out_strength", 32'(want.strength), 32'(rsp_if.out_strength));
            check_field("out_id", 32'(want.id), 32'(rsp_if.out_id));
            check_field("reported_count", 32'(want.count), 32'(rsp_if.reported_count));
            check_field("last", 32'(want.last), 32'(rsp_if.last));
            reports_checked++;
         end
      end
   end

   function automatic int dim_eff(input logic [DIM_W-1:0] d);
      if (d == '0) return 1;
      if (int'(d) > DIM_TOP) return DIM_TOP;
      return int'(d);
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_to(input int v, input int hi);
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      return COORD_BITS'(v);
   endfunction

   function automatic void map_raw(input logic [RAW_W-1:0] rx_in, input logic [RAW_W-1:0] ry_in,
                                   output logic [COORD_BITS-1:0] ox,
                                   output logic [COORD_BITS-1:0] oy);
      int w, h, rx, ry, x, y, mx, my;
      w = dim_eff(cfg_width);
      h = dim_eff(cfg_height);
      rx = int'(rx_in);
      ry = int'(ry_in);
      case (cfg_rotation)
         ROT_90: begin
            x = ry;
            y = w - rx;
         end
         ROT_180: begin
            x = w - rx;
            y = h - ry;
         end
         ROT_270: begin
            x = h - ry;
            y = rx;
         end
         default: begin
            x = rx;
            y = ry;
         end
      endcase
      if (cfg_rotation[0]) begin
         mx = h - 1;
         my = w - 1;
      end else begin
         mx = w - 1;
         my = h - 1;
      end
      ox = clamp_to(x, mx);
      oy = clamp_to(y, my);
   endfunction

   function automatic void push_cached_frame();
      touch_report_type r;
      int lim, n;
      lim = int'(cfg_limit);
      if (lim == 0) lim = 1;
      if (lim > MAX_PTS) lim = MAX_PTS;
      n = (cached_count < lim) ? cached_count : lim;
      for (int i = 0; i < n; i++) begin
         r.x = cache_x[i];
         r.y = cache_y[i];
         r.strength = cache_strength[i];
         r.id = ID_W'(i);
         r.count = RCOUNT_W'(n);
         r.last = (i == n - 1);
         pending_reports.push_back(r);
      end
   endfunction

   function automatic void resolve_empty_poll();
      touch_report_type r;
      write_idx = 0;
      if (touch_active && elapsed < int'(cfg_debounce) && cached_count != 0) begin
         push_cached_frame();
      end else begin
         touch_active = 1'b0;
         cached_count = 0;
         r = '0;
         r.last = 1'b1;
         pending_reports.push_back(r);
      end
   endfunction

   function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                        input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                                        input logic [AREA_W-1:0] area,
                                        input logic [FCOUNT_W-1:0] fc, input logic fend);
      int n;
      case (kind)
         KIND_TICK: begin
            if (elapsed < ELAPSED_TOP) elapsed++;
         end
         KIND_EMPTY: begin
            resolve_empty_poll();
         end
         KIND_POINT: begin
            if (fc != '0 && write_idx < MAX_PTS) begin
               map_raw(rx, ry, cache_x[write_idx], cache_y[write_idx]);
               cache_strength[write_idx] = area;
               write_idx++;
            end
            if (fend) begin
               if (fc == '0) begin
                  resolve_empty_poll();
               end else begin
                  n = int'(fc);
                  if (n > MAX_PTS) n = MAX_PTS;
                  if (n > write_idx) n = write_idx;
                  write_idx = 0;
                  touch_active = 1'b1;
                  cached_count = n;
                  elapsed = 0;
                  push_cached_frame();
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   function automatic logic [AREA_W-1:0] pick_area();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return AREA_W'($urandom);
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(9))
         0: return '0;
         1: return DIM_W'(1);
         2: return DIM_W'(DIM_TOP);
         3: return '1;
         default: return DIM_W'($urandom_range(2, DIM_TOP - 1));
      endcase
   endfunction

   function automatic logic [MS_W-1:0] pick_debounce();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return MS_W'($urandom_range(1, 24));
      endcase
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [RAW_W-1:0] rx,
                            input logic [RAW_W-1:0] ry, input logic [AREA_W-1:0] area,
                            input logic [FCOUNT_W-1:0] fc, input logic fend);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.raw_x <= rx;
      req_if.raw_y <= ry;
      req_if.raw_area <= area;
      req_if.frame_count <= fc;
      req_if.frame_end <= fend;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_item(kind, rx, ry, area, fc, fend);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic send_frame(input int npts, input logic [FCOUNT_W-1:0] fc);
      for (int i = 0; i < npts; i++) begin
         send_item(KIND_POINT, pick_raw(), pick_raw(), pick_area(), fc, i == npts - 1);
      end
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, pick_raw(), pick_raw(), pick_area(), FCOUNT_W'($urandom),
                1'($urandom));
   endtask

   task automatic send_empty_poll();
      send_item(KIND_EMPTY, pick_raw(), pick_raw(), pick_area(), FCOUNT_W'($urandom),
                1'($urandom));
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.data <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         CSR_ROTATION:     cfg_rotation = data[ROT_W-1:0];
         CSR_PANEL_WIDTH:  cfg_width = data[DIM_W-1:0];
         CSR_PANEL_HEIGHT: cfg_height = data[DIM_W-1:0];
         CSR_DEBOUNCE_MS:  cfg_debounce = data[MS_W-1:0];
         CSR_REPORT_LIMIT: cfg_limit = data[LIMIT_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [ROT_W-1:0] rot, input logic [DIM_W-1:0] w,
                                 input logic [DIM_W-1:0] h, input logic [MS_W-1:0] dbn,
                                 input logic [LIMIT_W-1:0] lim);
      settle_block();
      write_reg(CSR_ROTATION, CSR_DAT_W'(rot));
      write_reg(CSR_PANEL_WIDTH, CSR_DAT_W'(w));
      write_reg(CSR_PANEL_HEIGHT, CSR_DAT_W'(h));
      write_reg(CSR_DEBOUNCE_MS, CSR_DAT_W'(dbn));
      write_reg(CSR_REPORT_LIMIT, CSR_DAT_W'(lim));
      tick_span = (dbn > 40) ? 44 : int'(dbn) + 4;
   endtask

   task automatic test_directed();
      send_empty_poll();
      send_item(KIND_UNUSED, '1, '1, '1, '1, 1'b1);
      send_item(KIND_POINT, '0, '0, '0, FCOUNT_W'(2), 1'b0);
      send_item(KIND_POINT, '1, '1, '1, FCOUNT_W'(2), 1'b1);
      send_empty_poll();
      send_frame(MAX_PTS + 1, '1);
      send_item(KIND_POINT, pick_raw(), pick_raw(), pick_area(), '0, 1'b1);
      send_item(KIND_POINT, pick_raw(), pick_raw(), pick_area(), FCOUNT_W'(3), 1'b1);
      send_item(KIND_POINT, pick_raw(), pick_raw(), pick_area(), FCOUNT_W'(2), 1'b0);
      send_empty_poll();
      apply_settings(ROT_0, WIDTH_RST, HEIGHT_RST, '0, LIMIT_W'(LIMIT_RST));
      send_empty_poll();
      apply_settings(ROT_0, WIDTH_RST, HEIGHT_RST, MS_W'(2), LIMIT_W'(1));
      send_frame(3, FCOUNT_W'(3));
      send_tick();
      send_empty_poll();
      send_tick();
      send_empty_poll();
   endtask

   task automatic test_rotation_bounds();
      logic [DIM_W-1:0] w, h;
      for (int r = 0; r < 4; r++) begin
         case (r)
            0: begin w = DIM_W'(1); h = DIM_W'(DIM_TOP); end
            1: begin w = '0; h = '1; end
            2: begin w = DIM_W'(DIM_TOP); h = DIM_W'(7); end
            default: begin w = '1; h = DIM_W'(1); end
         endcase
         apply_settings(ROT_W'(r), w, h, DEBOUNCE_RST, '1);
         send_item(KIND_POINT, '0, '0, '0, FCOUNT_W'(2), 1'b0);
         send_item(KIND_POINT, '1, '1, '1, FCOUNT_W'(2), 1'b1);
      end
   endtask

   task automatic test_random_traffic(input logic [ROT_W-1:0] rot, input int target);
      int start_count, pick, npts;
      logic [FCOUNT_W-1:0] fc;
      apply_settings(rot, pick_dim(), pick_dim(), pick_debounce(),
                     LIMIT_W'($urandom_range(0, 7)));
      start_count = items_sent;
      while (items_sent - start_count < target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            npts = $urandom_range(1, MAX_PTS + 2);
            case ($urandom_range(9))
               0: fc = FCOUNT_W'($urandom_range(MAX_PTS + 1, 255));
               1: fc = FCOUNT_W'($urandom_range(0, npts));
               2: fc = '1;
               default: fc = FCOUNT_W'(npts);
            endcase
            send_frame(npts, fc);
         end else if (pick < 72) begin
            repeat ($urandom_range(1, tick_span)) send_tick();
         end else if (pick < 88) begin
            send_empty_poll();
         end else if (pick < 95) begin
            npts = $urandom_range(1, MAX_PTS);
            for (int i = 0; i < npts; i++) begin
               send_item(KIND_POINT, pick_raw(), pick_raw(), pick_area(),
                         FCOUNT_W'($urandom), $urandom_range(3) == 0);
            end
            send_empty_poll();
         end else begin
            send_item(KIND_UNUSED, pick_raw(), pick_raw(), pick_area(), FCOUNT_W'($urandom),
                      1'($urandom));
         end
      end
   endtask

   task automatic test_backpressure();
      int saved_pct;
      saved_pct = req_idle_pct;
      apply_settings(ROT_0, WIDTH_RST, HEIGHT_RST, DEBOUNCE_RST, LIMIT_W'(LIMIT_RST));
      req_idle_pct = 0;
      @(posedge clock);
      rsp_hold_req = 300;
      repeat (10) send_frame(MAX_PTS, FCOUNT_W'(MAX_PTS));
      settle_block();
      req_idle_pct = saved_pct;
   endtask

   task automatic test_debounce_expiry();
      apply_settings(ROT_180, WIDTH_RST, HEIGHT_RST, MS_W'(20), LIMIT_W'(LIMIT_RST));
      send_frame(3, FCOUNT_W'(3));
      repeat (20) send_tick();
      send_empty_poll();
      send_frame(2, FCOUNT_W'(2));
      repeat (19) send_tick();
      send_empty_poll();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind = KIND_TICK;
      req_if.raw_x = '0;
      req_if.raw_y = '0;
      req_if.raw_area = '0;
      req_if.frame_count = '0;
      req_if.frame_end = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.reg_index = CSR_ROTATION;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
      rsp_hold_req = 0;
      hold_left = 0;
      items_sent = 0;
      reports_checked = 0;
      mismatches = 0;
      cycle_count = 0;
      tick_span = 8;
      cfg_rotation = ROTATION_RST;
      cfg_width = WIDTH_RST;
      cfg_height = HEIGHT_RST;
      cfg_debounce = DEBOUNCE_RST;
      cfg_limit = LIMIT_W'(LIMIT_RST);
      touch_active = 1'b0;
      cached_count = 0;
      elapsed = 0;
      write_idx = 0;
      req_idle_pct = 17;
      rsp_idle_pct = 72;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_rotation_bounds();
      test_random_traffic(ROT_90, 30);
      test_random_traffic(ROT_0, 30);
      test_backpressure();
      req_idle_pct = 72;
      rsp_idle_pct = 17;
      test_random_traffic(ROT_180, 30);
      test_random_traffic(ROT_270, 30);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_debounce_expiry();
      test_random_traffic(ROT_90, 30);
      test_random_traffic(ROT_270, 30);
      settle_block();

      $display("Run covered %0d input transactions and %0d result transactions,", items_sent,
               reports_checked);
      $display("over all four rotations, clamped panel sizes, report limits and debounce times.");
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: touch_hold_debounce_rotate.f
rtl/core/thdr_pkg.sv
rtl/core/thdr_ifs.sv
rtl/core/thdr_ram.sv
rtl/core/thdr_map.sv
rtl/core/touch_hold_debounce_rotate.sv
tb/testbench.sv
